@@ sv/muv_pkg.sv @@
// ----------------------------------------------------------------------------
// muv_pkg
// Shared types, byte-class constants and the per-byte scan function of the
// Modified UTF-8 validator.
// ----------------------------------------------------------------------------
package muv_pkg;

  localparam int ByteW = 8;

  localparam logic [1:0] ContTag   = 2'b10;   // 10xxxxxx
  localparam logic [2:0] Lead2Tag  = 3'b110;  // 110xxxxx
  localparam logic [3:0] Lead3Tag  = 4'b1110; // 1110xxxx
  localparam logic [3:0] SurrNib   = 4'hD;    // ED lead -> D000-DFFF block

  typedef struct packed {
    logic       error_seen;
    logic [1:0] bytes_owed;
    logic       surrogate_lead;
    logic       surrogate_hit;
  } scan_state_t;

  localparam scan_state_t ScanIdle = '{1'b0, 2'd0, 1'b0, 1'b0};
  localparam scan_state_t ScanErr  = '{1'b1, 2'd0, 1'b0, 1'b0};

  // Input beat held in the front register.
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             last;
  } in_beat_t;

  // Advance the scan by one byte; does not apply the end-of-string clear.
  function automatic scan_state_t scan_next(scan_state_t s, logic [ByteW-1:0] b);
    scan_state_t n;
    n = s;
    if (!s.error_seen) begin
      if (s.bytes_owed != 2'd0) begin
        if (b[7:6] != ContTag) begin
          n = ScanErr;
        end else if (s.bytes_owed == 2'd2) begin
          // first continuation: bit 5 set puts ED xx in D800-DFFF
          n.surrogate_hit = s.surrogate_lead & b[5];
          n.bytes_owed    = 2'd1;
        end else begin
          n = s.surrogate_hit ? ScanErr : ScanIdle;
        end
      end else if (b == '0) begin
        n = ScanErr;
      end else if (!b[7]) begin
        n = s;
      end else if (b[7:5] == Lead2Tag) begin
        n.bytes_owed     = 2'd1;
        n.surrogate_lead = 1'b0;
        n.surrogate_hit  = 1'b0;
      end else if (b[7:4] == Lead3Tag) begin
        n.bytes_owed     = 2'd2;
        n.surrogate_lead = (b[3:0] == SurrNib);
        n.surrogate_hit  = 1'b0;
      end else begin
        n = ScanErr;
      end
    end
    return n;
  endfunction

endpackage

@@ sv/muv_in_reg.sv @@
// ----------------------------------------------------------------------------
// muv_in_reg
// Front register: captures one byte beat per cycle while it is empty or the
// checker stage takes its beat, and hands it on when that stage can take it.
// ----------------------------------------------------------------------------
module muv_in_reg import muv_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_beat_t in_beat,
  output logic     hold_valid,
  input  logic     hold_take,
  output in_beat_t hold_beat
);

  logic     vld;
  in_beat_t beat;

  assign in_ready   = !vld || hold_take;
  assign hold_valid = vld;
  assign hold_beat  = beat;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
    if (in_ready && in_valid) begin
      beat <= in_beat;
    end
  end

endmodule

@@ sv/muv_check.sv @@
// ----------------------------------------------------------------------------
// muv_check
// Scan state and result register: updates the scan state from the held byte
// and registers the verdict for the string as if it ended at that byte.
// ----------------------------------------------------------------------------
module muv_check import muv_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     hold_valid,
  output logic     hold_take,
  input  in_beat_t hold_beat,
  output logic     res_valid,
  input  logic     res_ready,
  output logic     valid_res,
  output logic     done_res
);

  scan_state_t state;
  scan_state_t scan;
  scan_state_t state_next;
  logic        rvld;
  logic        verdict_next;

  assign hold_take = !rvld || res_ready;

  always_comb begin
    scan         = scan_next(state, hold_beat.data_byte);
    verdict_next = !scan.error_seen && (scan.bytes_owed == 2'd0);
    state_next   = hold_beat.last ? ScanIdle : scan;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ScanIdle;
      rvld  <= 1'b0;
    end else begin
      if (hold_take) begin
        rvld <= hold_valid;
      end
      if (hold_take && hold_valid) begin
        state <= state_next;
      end
    end
    if (hold_take && hold_valid) begin
      valid_res <= verdict_next;
      done_res  <= hold_beat.last;
    end
  end

  assign res_valid = rvld;

endmodule

@@ sv/modified_utf8_validator.sv @@
// ----------------------------------------------------------------------------
// modified_utf8_validator
// Byte-stream Modified UTF-8 checker with a per-byte verdict.
// ----------------------------------------------------------------------------
// One byte is taken per cycle until a stall; each byte gives one output beat,
// registered in the front register, then the result register, and the output
// beat says whether the string would be valid if it ended at that byte.
// Zero bytes, stray continuation bytes, leads 0xF0 and up, short sequences
// and three-byte encodings of D800-DFFF fail; overlong forms pass. Errors
// stick until the beat with tlast, after which a new string starts. A
// back-pressured output stalls the input only once both registers are full.
module modified_utf8_validator import muv_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // last
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [0] valid_res, [7:1] zero
  output logic       m_tlast    // done_res
);

  in_beat_t in_beat;
  in_beat_t hold_beat;
  logic     hold_valid;
  logic     hold_take;
  logic     valid_res;

  assign in_beat.data_byte = s_tdata;
  assign in_beat.last      = s_tlast;

  muv_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_beat    (in_beat),
    .hold_valid (hold_valid),
    .hold_take  (hold_take),
    .hold_beat  (hold_beat)
  );

  muv_check u_check (
    .clk        (clk),
    .rst        (rst),
    .hold_valid (hold_valid),
    .hold_take  (hold_take),
    .hold_beat  (hold_beat),
    .res_valid  (m_tvalid),
    .res_ready  (m_tready),
    .valid_res  (valid_res),
    .done_res   (m_tlast)
  );

  assign m_tdata = {7'd0, valid_res};

endmodule

@@ sv/muv_checker.sv @@
// ----------------------------------------------------------------------------
// muv_checker
// Port-level checks for the Modified UTF-8 validator, bound to the top level.
// ----------------------------------------------------------------------------
module muv_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic [7:0] s_tdata,
  input logic       s_tlast,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  // nothing comes out in the cycle right after reset
  a_quiet_after_rst: assert property (@(posedge clk)
    !rst && $past(rst) |-> !m_tvalid)
    else $error("output beat right after reset");

  // input stalls only when a result is waiting at the output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with empty output");

  // padding bits above the verdict stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:1] == 7'd0))
    else $error("nonzero padding in m_tdata");

  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output beat changed under back-pressure");

endmodule

bind modified_utf8_validator muv_checker u_muv_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Modified UTF-8 validator. A short directed set
// of strings covers the corner cases: NUL, stray continuation bytes, leads
// 0xF0 and up, truncated sequences, surrogate encodings, overlong forms and
// sticky errors. After that, random strings are sent. They are built mostly
// from well-formed characters and noise bytes, some truncated or corrupted. A
// scoreboard tracks the scan state of each string and checks every output
// beat against the expected per-byte verdict. Both stream sides idle at
// random.
// ----------------------------------------------------------------------------
module tb import muv_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic ok;    // string valid if it ended here
    logic fin;   // last byte of the string
  } verdict_t;

  class utf8_scoreboard;
    scan_state_t scan;
    verdict_t    verdict_q[$];
    int          fails;

    function new();
      scan  = ScanIdle;
      fails = 0;
    endfunction

    function void flag_error();
      scan = ScanErr;
    endfunction

    // Advance the expected scan state by one accepted byte.
    function void note_byte(logic [7:0] b, logic fin);
      verdict_t v;
      logic     hit;
      if (!scan.error_seen) begin
        if (scan.bytes_owed != 2'd0) begin
          if (b[7:6] != ContTag) begin
            flag_error();
          end else if (scan.bytes_owed == 2'd2) begin
            // ED followed by A0..BF lands in D800-DFFF
            scan.surrogate_hit = scan.surrogate_lead & b[5];
            scan.bytes_owed    = 2'd1;
          end else begin
            hit  = scan.surrogate_hit;
            scan = ScanIdle;
            if (hit) flag_error();
          end
        end else if (b == 8'h00) begin
          flag_error();
        end else if (b[7]) begin
          if (b[7:5] == Lead2Tag) begin
            scan.bytes_owed     = 2'd1;
            scan.surrogate_lead = 1'b0;
            scan.surrogate_hit  = 1'b0;
          end else if (b[7:4] == Lead3Tag) begin
            scan.bytes_owed     = 2'd2;
            scan.surrogate_lead = (b[3:0] == SurrNib);
            scan.surrogate_hit  = 1'b0;
          end else begin
            flag_error();
          end
        end
      end
      v.ok  = !scan.error_seen && (scan.bytes_owed == 2'd0);
      v.fin = fin;
      verdict_q.push_back(v);
      if (fin) scan = ScanIdle;
    endfunction

    function void check_beat(logic [7:0] data, logic fin);
      verdict_t v;
      if (verdict_q.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("%0t: output beat with nothing expected: data=%02h last=%b",
                   $realtime, data, fin);
        return;
      end
      v = verdict_q.pop_front();
      if (data !== {7'b0, v.ok} || fin !== v.fin) begin
        fails++;
        if (fails <= 10)
          $display("%0t: verdict mismatch: exp valid=%b last=%b, got data=%02h last=%b",
                   $realtime, v.ok, v.fin, data, fin);
      end
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction
  endclass

  typedef enum {RX_OPEN, RX_RANDOM, RX_CHOKE, RX_PATTERN} rx_mode_t;

  logic       clk;
  logic       rst      = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = 8'h00;
  logic       s_tlast  = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;

  utf8_scoreboard sb = new();

  rx_mode_t   rx_mode   = RX_OPEN;
  int         rx_left   = 0;
  int         rx_phase  = 0;
  int         burst_left = 0;
  int         bytes_sent = 0;
  logic [7:0] str_q[$];

  // bit 8 marks the last byte of a string
  localparam logic [8:0] DirSeq [24] = '{
    9'h141,                 // single ASCII
    9'h100,                 // NUL
    9'h07F, 9'h101,         // ASCII extremes
    9'h0C0, 9'h180,         // overlong two-byte NUL, accepted
    9'h0EF, 9'h0BF, 9'h1BF, // U+FFFF
    9'h0ED, 9'h0A0, 9'h180, // surrogate D800
    9'h0ED, 9'h09F, 9'h1BF, // U+D7FF, just below surrogates
    9'h180,                 // stray continuation as lead
    9'h0F0, 9'h141,         // four-byte lead, error sticks
    9'h1FF,                 // 0xFF lead
    9'h0E2, 9'h182,         // three-byte cut short
    9'h0C3, 9'h141,         // missing continuation
    9'h1DF                  // two-byte cut short
  };

  modified_utf8_validator dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Both handshakes are sampled here, before this edge's updates land.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) sb.check_beat(m_tdata, m_tlast);
    end
  end

  // Receiver: switches between open, random, choked and a fixed duty pattern.
  always @(posedge clk) begin
    rx_phase <= rx_phase + 1;
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(16, 96);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:    m_tready <= 1'b1;
      RX_RANDOM:  m_tready <= 1'($urandom_range(0, 1));
      RX_CHOKE:   m_tready <= ($urandom_range(0, 3) == 0);
      default:    m_tready <= (rx_phase % 7) < 4;
    endcase
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= fin;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Mostly well-formed characters; some noise bytes, truncation and corruption.
  task automatic build_string();
    int nchars;
    int kind;
    int cut;
    str_q.delete();
    nchars = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
    repeat (nchars) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        str_q.push_back(8'($urandom_range(1, 127)));
      end else if (kind < 55) begin
        str_q.push_back({3'b110, 5'($urandom)});
        str_q.push_back({2'b10, 6'($urandom)});
      end else if (kind < 88) begin
        if ($urandom_range(0, 2) == 0) str_q.push_back(8'hED);
        else str_q.push_back({4'b1110, 4'($urandom)});
        str_q.push_back({2'b10, 6'($urandom)});
        str_q.push_back({2'b10, 6'($urandom)});
      end else if (kind < 92) begin
        str_q.push_back(8'h00);
      end else if (kind < 96) begin
        str_q.push_back({2'b10, 6'($urandom)});
      end else begin
        str_q.push_back(8'($urandom_range(8'hF0, 8'hFF)));
      end
    end
    if ($urandom_range(0, 9) == 0 && str_q.size() > 1) begin
      cut = $urandom_range(1, str_q.size() - 1);
      while (str_q.size() > cut) void'(str_q.pop_back());
    end
    if ($urandom_range(0, 9) == 0)
      str_q[$urandom_range(0, str_q.size() - 1)] = 8'($urandom);
  endtask

  initial begin
    bit paused;
    paused = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (DirSeq[i]) send_byte(DirSeq[i][7:0], DirSeq[i][8]);
    drain();

    bytes_sent = 0;
    while (bytes_sent < 850) begin
      build_string();
      foreach (str_q[i]) send_byte(str_q[i], i == str_q.size() - 1);
      if (!paused && bytes_sent >= 400) begin
        paused = 1'b1;
        drain();
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("** modified_utf8_validator: PASSED **");
    end else begin
      $display("** modified_utf8_validator: FAILED **");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout with %0d beats outstanding", sb.pending());
    $display("** modified_utf8_validator: FAILED **");
    $finish;
  end

endmodule

@@ files.f @@
sv/muv_pkg.sv
sv/muv_in_reg.sv
sv/muv_check.sv
sv/modified_utf8_validator.sv
sv/muv_checker.sv
tb/sv/tb.sv
